// File: src/bmp24fb_pkg.sv
package bmp24fb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);

  localparam int HEADER_LEN = 54;
  localparam int OFS_MAGIC  = 1;
  localparam int OFS_DATA   = 13;
  localparam int OFS_WIDTH  = 21;
  localparam int OFS_HEIGHT = 25;
  localparam int OFS_BPP    = 29;
  localparam int OFS_COMP   = 33;

  localparam logic [15:0] BMP_MAGIC = 16'h4D42;
  localparam logic [15:0] BMP_BPP   = 16'd24;
  localparam logic [7:0]  ALPHA     = 8'hFF;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_BASE  = 3'd0;
  localparam logic [2:0] REG_LINE_STRIDE = 3'd1;
  localparam logic [2:0] REG_SCREEN_COLS = 3'd2;
  localparam logic [2:0] REG_SCREEN_ROWS = 3'd3;
  localparam logic [2:0] REG_DEST_X      = 3'd4;
  localparam logic [2:0] REG_DEST_Y      = 3'd5;

  localparam logic [14:0] LINE_STRIDE_RST = 15'd3200;
  localparam logic [12:0] SCREEN_COLS_RST = 13'd800;
  localparam logic [12:0] SCREEN_ROWS_RST = 13'd480;

  // status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
  localparam logic [2:0] ST_OFF_SCREEN = 3'd4;
  localparam logic [2:0] ST_BAD_LAYOUT = 3'd5;
  localparam logic [2:0] ST_TRUNCATED  = 3'd6;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] fb_address;
    logic [31:0] pixel_word;
    logic [2:0]  status;
    logic        image_end;
  } result_t;

  // signed header dimension; zero when negative, zero or too large
  function automatic logic [DIM_W-1:0] take_dim(input logic [31:0] v);
    logic [DIM_W-1:0] r;
    r = '0;
    if (!v[31] && v != 32'd0 && v <= 32'(MAX_DIM)) begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/bmp24_to_framebuffer_writer.sv
// Streams a 24-bit uncompressed BMP file in one byte per transaction and emits
// framebuffer writes of BGRA words (alpha 0xFF), flipping the bottom-up rows
// onto the screen at (dest_x, dest_y) and dropping row padding. One byte is
// taken every cycle; each byte is handled in the cycle it is accepted and any
// result lands in an output register backed by a one-entry skid register, so
// input only stalls once both hold results. Pixel writes come out on the red
// byte; the final result of an image has image_end set with a status code.
// The address is frame_base + row*line_stride + col*4 from the current
// registers, computed with one 13x15 multiply. After an error without
// end_of_file, bytes are dropped through the next end_of_file byte.
module bmp24_to_framebuffer_writer
  import bmp24fb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [31:0] fb_address,
  output logic [31:0] pixel_word,
  output logic [2:0]  status,
  output logic        image_end,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic [31:0] frame_base;
  logic [14:0] line_stride;
  logic [12:0] screen_cols;
  logic [12:0] screen_rows;
  logic [11:0] dest_x;
  logic [11:0] dest_y;

  // parser state
  phase_t           phase, phase_next;
  logic [31:0]      file_offset, file_offset_next;
  logic [31:0]      field_shift, field_shift_next;
  logic [31:0]      data_start, data_start_next;
  logic [DIM_W-1:0] image_cols, image_cols_next;
  logic [DIM_W-1:0] image_rows, image_rows_next;
  logic             format_bad, format_bad_next;
  logic [CNT_W-1:0] col, col_next;
  logic [CNT_W-1:0] rows_left, rows_left_next;
  logic [1:0]       part, part_next;
  logic             in_pad, in_pad_next;
  logic [1:0]       pad_left, pad_left_next;
  logic [7:0]       held_blue, held_blue_next;
  logic [7:0]       held_green, held_green_next;

  // output registers
  result_t out_reg, skid_reg, res;
  logic    skid_valid;

  logic             in_accept;
  logic             ended;
  logic             res_valid;
  logic [31:0]      fs_shifted;
  logic [DIM_W-1:0] rows_m1;
  logic [13:0]      fit_x, fit_y;
  logic [12:0]      srow;
  logic [12:0]      xcol;
  logic [27:0]      row_offset;
  logic             last_col;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;

  assign fs_shifted = {file_byte, field_shift[31:8]};
  assign rows_m1    = image_rows - DIM_W'(1);
  assign fit_x      = 14'(dest_x) + 14'(image_cols);
  assign fit_y      = 14'(dest_y) + 14'(image_rows);
  assign srow       = 13'(dest_y) + 13'(rows_left);
  assign xcol       = 13'(dest_x) + 13'(col);
  assign row_offset = srow * line_stride;
  assign last_col   = (DIM_W'(col) + DIM_W'(1)) == image_cols;

  always_comb begin
    phase_next       = phase;
    file_offset_next = file_offset;
    field_shift_next = field_shift;
    data_start_next  = data_start;
    image_cols_next  = image_cols;
    image_rows_next  = image_rows;
    format_bad_next  = format_bad;
    col_next         = col;
    rows_left_next   = rows_left;
    part_next        = part;
    in_pad_next      = in_pad;
    pad_left_next    = pad_left;
    held_blue_next   = held_blue;
    held_green_next  = held_green;
    ended            = 1'b0;
    res              = '0;

    if (in_accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (end_of_file) begin
            phase_next       = PH_HEADER;
            file_offset_next = '0;
            format_bad_next  = 1'b0;
          end
        end
        PH_HEADER: begin
          field_shift_next = fs_shifted;
          file_offset_next = file_offset + 32'd1;
          if (file_offset == 32'(OFS_MAGIC) && fs_shifted[31:16] != BMP_MAGIC
              && !end_of_file) begin
            ended      = 1'b1;
            res.status = ST_BAD_MAGIC;
          end else if (file_offset == 32'(OFS_DATA)) begin
            data_start_next = fs_shifted;
          end else if (file_offset == 32'(OFS_WIDTH)) begin
            image_cols_next = take_dim(fs_shifted);
          end else if (file_offset == 32'(OFS_HEIGHT)) begin
            image_rows_next = take_dim(fs_shifted);
          end else if (file_offset == 32'(OFS_BPP)) begin
            if (fs_shifted[31:16] != BMP_BPP) format_bad_next = 1'b1;
          end else if (file_offset == 32'(OFS_COMP)) begin
            if (fs_shifted != 32'd0) format_bad_next = 1'b1;
          end else if (file_offset == 32'(HEADER_LEN - 1)) begin
            if (format_bad) begin
              ended      = 1'b1;
              res.status = ST_BAD_FORMAT;
            end else if (image_cols == '0 || image_rows == '0
                         || data_start < 32'(HEADER_LEN)) begin
              ended      = 1'b1;
              res.status = ST_BAD_LAYOUT;
            end else if (fit_x > 14'(screen_cols) || fit_y > 14'(screen_rows)) begin
              ended      = 1'b1;
              res.status = ST_OFF_SCREEN;
            end else begin
              phase_next     = (data_start == 32'(HEADER_LEN)) ? PH_PIXELS : PH_SKIP;
              col_next       = '0;
              rows_left_next = rows_m1[CNT_W-1:0];
              part_next      = 2'd0;
              in_pad_next    = 1'b0;
              pad_left_next  = 2'd0;
            end
          end
        end
        PH_SKIP: begin
          if (file_offset + 32'd1 == data_start) phase_next = PH_PIXELS;
          file_offset_next = file_offset + 32'd1;
        end
        PH_PIXELS: begin
          if (in_pad) begin
            pad_left_next = pad_left - 2'd1;
            if (pad_left == 2'd1) begin
              in_pad_next    = 1'b0;
              rows_left_next = rows_left - CNT_W'(1);
            end
          end else begin
            case (part)
              2'd0: begin
                held_blue_next = file_byte;
                part_next      = 2'd1;
              end
              2'd1: begin
                held_green_next = file_byte;
                part_next       = 2'd2;
              end
              default: begin
                part_next       = 2'd0;
                res.write_valid = 1'b1;
                res.fb_address  = frame_base + 32'(row_offset) + {17'd0, xcol, 2'b00};
                res.pixel_word  = {ALPHA, file_byte, held_green, held_blue};
                if (last_col) begin
                  col_next = '0;
                  // padding to a multiple of 4 bytes equals cols mod 4
                  if (image_cols[1:0] != 2'd0) begin
                    in_pad_next   = 1'b1;
                    pad_left_next = image_cols[1:0];
                  end else begin
                    rows_left_next = rows_left - CNT_W'(1);
                  end
                  if (rows_left == '0) begin
                    ended      = 1'b1;
                    res.status = ST_DONE;
                  end
                end else begin
                  col_next = col + CNT_W'(1);
                end
              end
            endcase
          end
        end
        default: ;
      endcase

      if (phase != PH_IDLE) begin
        if (!ended && end_of_file) begin
          ended      = 1'b1;
          res.status = ST_TRUNCATED;
        end
        if (ended) begin
          if (end_of_file) begin
            phase_next       = PH_HEADER;
            file_offset_next = '0;
            format_bad_next  = 1'b0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
    end
    res.image_end = ended;
  end

  assign res_valid = in_accept && (ended || res.write_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= '0;
      line_stride <= LINE_STRIDE_RST;
      screen_cols <= SCREEN_COLS_RST;
      screen_rows <= SCREEN_ROWS_RST;
      dest_x      <= '0;
      dest_y      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_BASE:  frame_base  <= cfg_data;
        REG_LINE_STRIDE: line_stride <= cfg_data[14:0];
        REG_SCREEN_COLS: screen_cols <= cfg_data[12:0];
        REG_SCREEN_ROWS: screen_rows <= cfg_data[12:0];
        REG_DEST_X:      dest_x      <= cfg_data[11:0];
        REG_DEST_Y:      dest_y      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      file_offset <= '0;
      format_bad  <= 1'b0;
    end else begin
      phase       <= phase_next;
      file_offset <= file_offset_next;
      format_bad  <= format_bad_next;
    end
    field_shift <= field_shift_next;
    data_start  <= data_start_next;
    image_cols  <= image_cols_next;
    image_rows  <= image_rows_next;
    col         <= col_next;
    rows_left   <= rows_left_next;
    part        <= part_next;
    in_pad      <= in_pad_next;
    pad_left    <= pad_left_next;
    held_blue   <= held_blue_next;
    held_green  <= held_green_next;
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_reg  <= skid_reg;
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign write_valid = out_reg.write_valid;
  assign fb_address  = out_reg.fb_address;
  assign pixel_word  = out_reg.pixel_word;
  assign status      = out_reg.status;
  assign image_end   = out_reg.image_end;

endmodule
